/* design/jld_pkg.sv */
// Shared types and constants of the jump and landing detector.
package jld_pkg;

	// Widths of the item fields and configuration registers.
	localparam int FORCE_W = 10;
	localparam int TIME_W  = 32;
	localparam int AIR_W   = 16;
	localparam int PHASE_W = 3;
	localparam int HOLD_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PH_GROUND     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_MAYBE_JUMP = 3'd1;
	localparam logic [PHASE_W-1:0] PH_AIR        = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MAYBE_LAND = 3'd3;
	localparam logic [PHASE_W-1:0] PH_LANDING    = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAND_HOLD = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [FORCE_W-1:0] THRESHOLD_RST = 10'd80;
	localparam logic [HOLD_W-1:0]  LAND_HOLD_RST = 16'd1000;

	localparam logic [AIR_W-1:0] AIR_MAX = '1;

	typedef struct packed {
		logic               op;
		logic [FORCE_W-1:0] force_req;
		logic [TIME_W-1:0]  now_ms;
	} in_item_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               jumped;
		logic               landed;
		logic               ready_to_show;
		logic [AIR_W-1:0]   air_time_ms;
		logic [FORCE_W-1:0] peak_takeoff;
		logic [FORCE_W-1:0] peak_landing;
	} res_item_t;

endpackage

/* design/jld_core.sv */
// Detector state registers and the per-item state update.
module jld_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  jld_pkg::in_item_t               item,
	input  logic [jld_pkg::FORCE_W-1:0]     threshold,
	input  logic [jld_pkg::HOLD_W-1:0]      land_hold_ms,
	output jld_pkg::res_item_t              res
);
	import jld_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [TIME_W-1:0]  takeoff_time_q, takeoff_time_d;
	logic [TIME_W-1:0]  landing_time_q, landing_time_d;
	logic [AIR_W-1:0]   air_time_q, air_time_d;
	logic [FORCE_W-1:0] peak_to_q, peak_to_d;
	logic [FORCE_W-1:0] peak_land_q, peak_land_d;
	logic               jumped_q, jumped_d;
	logic               landed_q, landed_d;
	logic               show_q, show_d;

	logic [TIME_W-1:0]  air_diff;
	logic [TIME_W-1:0]  land_diff;
	logic               below, above, in_window;
	logic [FORCE_W-1:0] peak_to_max, peak_land_max;

	assign air_diff  = item.now_ms - takeoff_time_q;
	assign land_diff = item.now_ms - landing_time_q;
	assign below     = item.force_req < threshold;
	assign above     = item.force_req > threshold;
	assign in_window = (land_diff[TIME_W-1:HOLD_W] == '0)
		&& (land_diff[HOLD_W-1:0] < land_hold_ms);
	assign peak_to_max   = (item.force_req > peak_to_q) ? item.force_req : peak_to_q;
	assign peak_land_max = (item.force_req > peak_land_q) ? item.force_req : peak_land_q;

	always_comb begin
		phase_d        = phase_q;
		takeoff_time_d = takeoff_time_q;
		landing_time_d = landing_time_q;
		air_time_d     = air_time_q;
		peak_to_d      = peak_to_q;
		peak_land_d    = peak_land_q;
		jumped_d       = jumped_q;
		landed_d       = landed_q;
		show_d         = show_q;
		if (item.op == OP_CLEAR) begin
			phase_d        = PH_GROUND;
			takeoff_time_d = '0;
			landing_time_d = '0;
			air_time_d     = '0;
			peak_to_d      = '0;
			peak_land_d    = '0;
			jumped_d       = 1'b0;
			landed_d       = 1'b0;
			show_d         = 1'b0;
		end else begin
			unique case (phase_q)
				PH_MAYBE_JUMP: begin
					peak_to_d = peak_to_max;
					if (below) begin
						phase_d        = PH_AIR;
						takeoff_time_d = item.now_ms;
						jumped_d       = 1'b1;
					end else begin
						phase_d = PH_GROUND;
					end
				end
				PH_AIR: begin
					if (above) begin
						phase_d = PH_MAYBE_LAND;
					end
				end
				PH_MAYBE_LAND: begin
					if (above) begin
						phase_d        = PH_LANDING;
						air_time_d     = (air_diff[TIME_W-1:AIR_W] != '0) ? AIR_MAX
							: air_diff[AIR_W-1:0];
						landing_time_d = item.now_ms;
						landed_d       = 1'b1;
						peak_land_d    = peak_land_max;
					end else begin
						phase_d = PH_AIR;
					end
				end
				PH_LANDING: begin
					if (in_window) begin
						peak_land_d = peak_land_max;
					end else begin
						phase_d = PH_GROUND;
						show_d  = 1'b1;
					end
				end
				default: begin
					// Ground, and any code that should never appear.
					peak_to_d = peak_to_max;
					phase_d   = below ? PH_MAYBE_JUMP : PH_GROUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_GROUND;
			takeoff_time_q <= '0;
			landing_time_q <= '0;
			air_time_q     <= '0;
			peak_to_q      <= '0;
			peak_land_q    <= '0;
			jumped_q       <= 1'b0;
			landed_q       <= 1'b0;
			show_q         <= 1'b0;
		end else if (adv) begin
			phase_q        <= phase_d;
			takeoff_time_q <= takeoff_time_d;
			landing_time_q <= landing_time_d;
			air_time_q     <= air_time_d;
			peak_to_q      <= peak_to_d;
			peak_land_q    <= peak_land_d;
			jumped_q       <= jumped_d;
			landed_q       <= landed_d;
			show_q         <= show_d;
		end
	end

	// The result shows the state after the update.
	always_comb begin
		res.phase         = phase_d;
		res.jumped        = jumped_d;
		res.landed        = landed_d;
		res.ready_to_show = show_d;
		res.air_time_ms   = air_time_d;
		res.peak_takeoff  = peak_to_d;
		res.peak_landing  = peak_land_d;
	end

endmodule

/* design/jump_landing_detector.sv */
// Top level of the force-sensor jump and landing detector.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------
//   in      | in_valid / in_ready   | in_item  (op, force_req, now_ms)
//   out     | out_valid / out_ready | out_item (phase, flags, times, peaks)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An accepted item is held in the input register, the state update is
// computed from it, and the result is written to the output register
// together with the new state, and is offered from there. One item per
// cycle is sustained while the output does not stall, set by the single
// state update.
// Reset clears the detector state and loads threshold 80 and a 1000 ms
// landing hold. A stalled output holds the input register, and the input
// side is still ready whenever the input register will move on.
module jump_landing_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  jld_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output jld_pkg::res_item_t                 out_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jld_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jld_pkg::*;

	logic               valid_s1;
	in_item_t           item_s1;
	logic               out_valid_q;
	res_item_t          out_item_q;
	res_item_t          res;
	logic               adv;
	logic [FORCE_W-1:0] threshold_q;
	logic [HOLD_W-1:0]  land_hold_q;

	// The input register moves into the output register when the output
	// register is empty or its item is being taken in this cycle.
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Configuration writes are taken at once; the user must send them only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			land_hold_q <= LAND_HOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[FORCE_W-1:0];
				CFG_LAND_HOLD: land_hold_q <= cfg_data[HOLD_W-1:0];
				default: begin
					// Writes to unknown indexes are dropped.
				end
			endcase
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	jld_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.item         (item_s1),
		.threshold    (threshold_q),
		.land_hold_ms (land_hold_q),
		.res          (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= res;
		end
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the jump and landing detector: directed and random items, checked against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jld_pkg::*;

	// Tracks the detector's phase, times, peaks and flags from every accepted
	// item, and keeps the status items that the block must return, oldest first.
	class jump_tracker;
		logic [FORCE_W-1:0] thr;
		logic [HOLD_W-1:0]  hold;
		logic [PHASE_W-1:0] phase;
		logic [TIME_W-1:0]  t_off;
		logic [TIME_W-1:0]  t_land;
		logic [AIR_W-1:0]   air;
		logic [FORCE_W-1:0] pk_off;
		logic [FORCE_W-1:0] pk_land;
		logic               f_jump;
		logic               f_land;
		logic               f_show;
		res_item_t          status_q[$];
		int                 errors;
		int                 checked;
		int                 takeoffs;
		int                 landings;

		function new();
			thr = THRESHOLD_RST;
			hold = LAND_HOLD_RST;
			errors = 0;
			checked = 0;
			takeoffs = 0;
			landings = 0;
			wipe();
		endfunction

		function void wipe();
			phase = PH_GROUND;
			t_off = '0;
			t_land = '0;
			air = '0;
			pk_off = '0;
			pk_land = '0;
			f_jump = 1'b0;
			f_land = 1'b0;
			f_show = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_THRESHOLD) begin
				thr = val[FORCE_W-1:0];
			end else if (idx == CFG_LAND_HOLD) begin
				hold = val[HOLD_W-1:0];
			end
		endfunction

		function void take_item(in_item_t it);
			logic [TIME_W-1:0] span;
			res_item_t st;
			if (it.op == OP_CLEAR) begin
				wipe();
			end else begin
				case (phase)
					PH_MAYBE_JUMP: begin
						if (it.force_req > pk_off)
							pk_off = it.force_req;
						// A second sample below the threshold confirms take-off.
						if (it.force_req < thr) begin
							phase = PH_AIR;
							t_off = it.now_ms;
							f_jump = 1'b1;
							takeoffs++;
						end else begin
							phase = PH_GROUND;
						end
					end
					PH_AIR: begin
						// A sample equal to the threshold still counts as air here.
						if (it.force_req > thr)
							phase = PH_MAYBE_LAND;
					end
					PH_MAYBE_LAND: begin
						if (it.force_req > thr) begin
							span = it.now_ms - t_off;
							phase = PH_LANDING;
							air = (span > TIME_W'(AIR_MAX)) ? AIR_MAX : span[AIR_W-1:0];
							t_land = it.now_ms;
							f_land = 1'b1;
							landings++;
							if (it.force_req > pk_land)
								pk_land = it.force_req;
						end else begin
							phase = PH_AIR;
						end
					end
					PH_LANDING: begin
						span = it.now_ms - t_land;
						if (span < TIME_W'(hold)) begin
							if (it.force_req > pk_land)
								pk_land = it.force_req;
						end else begin
							phase = PH_GROUND;
							f_show = 1'b1;
						end
					end
					default: begin
						if (it.force_req > pk_off)
							pk_off = it.force_req;
						phase = (it.force_req < thr) ? PH_MAYBE_JUMP : PH_GROUND;
					end
				endcase
			end
			st.phase = phase;
			st.jumped = f_jump;
			st.landed = f_land;
			st.ready_to_show = f_show;
			st.air_time_ms = air;
			st.peak_takeoff = pk_off;
			st.peak_landing = pk_land;
			status_q.push_back(st);
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_status(res_item_t got);
			res_item_t want;
			if (status_q.size() == 0) begin
				$error("status item returned with none outstanding");
				errors++;
				return;
			end
			want = status_q.pop_front();
			checked++;
			check_field("phase", 32'(want.phase), 32'(got.phase));
			check_field("jumped", 32'(want.jumped), 32'(got.jumped));
			check_field("landed", 32'(want.landed), 32'(got.landed));
			check_field("ready_to_show", 32'(want.ready_to_show),
				32'(got.ready_to_show));
			check_field("air_time_ms", 32'(want.air_time_ms), 32'(got.air_time_ms));
			check_field("peak_takeoff", 32'(want.peak_takeoff), 32'(got.peak_takeoff));
			check_field("peak_landing", 32'(want.peak_landing), 32'(got.peak_landing));
		endfunction
	endclass

	// The watchdog gives up after this many cycles in which nothing moves on any
	// channel. A correct run never comes close: every stall here is a short random one.
	localparam int QUIET_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	res_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jump_tracker board = new();

	int                idle_pct = 33;
	int                sent = 0;
	int                writes = 0;
	int                quiet = 0;
	int                thr_now = int'(THRESHOLD_RST);
	int                hold_now = int'(LAND_HOLD_RST);
	logic [TIME_W-1:0] clock_ms = '0;

	jump_landing_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random, at the same rate as the sender idles.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Every handshake is observed here at the rising edge. All stimulus is driven
	// with nonblocking assignments, so the values read are those that the block
	// saw at that edge. A result is checked before the item accepted at the same
	// edge is noted, since that item cannot have produced it yet.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_status(out_item);
		if (in_valid && in_ready)
			board.take_item(in_item);
		if (cfg_valid && cfg_ready) begin
			board.set_reg(cfg_index, cfg_data);
			writes++;
		end
		if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet == QUIET_LIMIT) begin
				$display("Timed out: no handshake for %0d cycles.", QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic in_item_t mk(logic op, logic [FORCE_W-1:0] f, logic [TIME_W-1:0] t);
		in_item_t it;
		it.op = op;
		it.force_req = f;
		it.now_ms = t;
		return it;
	endfunction

	// Offers one item, after a random gap now and then. Valid stays high from
	// one item to the next when there is no gap, so it is never lowered and
	// raised within the same edge.
	task automatic send(input in_item_t it);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		sent++;
	endtask

	task automatic sample_at(input int f, input logic [TIME_W-1:0] t);
		clock_ms = t;
		send(mk(OP_SAMPLE, FORCE_W'(f), t));
	endtask

	task automatic sample(input int f, input logic [TIME_W-1:0] dt);
		sample_at(f, clock_ms + dt);
	endtask

	// Waits until every outstanding status item has come back, so that the
	// block is idle. The first edge also lets the monitor note the last item.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// Writes both registers with valid held high across the pair.
	task automatic configure(input logic [CFG_DATA_W-1:0] thr_data,
			input logic [CFG_DATA_W-1:0] hold);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= thr_data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_index <= CFG_LAND_HOLD;
		cfg_data <= hold;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	// Forces that the current threshold sees as air or as ground. Now and then
	// the threshold itself is returned, which reads as ground before take-off
	// and as air after it.
	function automatic int low_force();
		if (thr_now == 0 || $urandom_range(99) < 12)
			return thr_now;
		return $urandom_range(thr_now - 1, 0);
	endfunction

	function automatic int high_force();
		if (thr_now == 1023 || $urandom_range(99) < 12)
			return thr_now;
		return $urandom_range(1023, thr_now + 1);
	endfunction

	// Time steps: mostly short, some long enough to saturate the air time, and
	// a few arbitrary ones that wrap the timestamp.
	function automatic logic [TIME_W-1:0] next_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(200, 0);
		if (r < 90)
			return $urandom_range(70000, 1000);
		return $urandom;
	endfunction

	// In the landing window most steps stay within the hold length.
	function automatic logic [TIME_W-1:0] hold_gap();
		if (hold_now == 0 || $urandom_range(99) < 40)
			return next_gap();
		return $urandom_range(hold_now, 0);
	endfunction

	// One well-formed jump with random content: ground contact, two samples
	// below the threshold, some air time, two above it and a landing window.
	// Each confirming pair is broken now and then to exercise the fall-backs.
	task automatic jump_cycle();
		repeat ($urandom_range(3, 1)) sample(high_force(), next_gap());
		sample(low_force(), next_gap());
		if ($urandom_range(99) < 15)
			sample(high_force(), next_gap());
		sample(low_force(), next_gap());
		repeat ($urandom_range(4, 0)) sample(low_force(), next_gap());
		sample(high_force(), next_gap());
		if ($urandom_range(99) < 15)
			sample(low_force(), next_gap());
		sample(high_force(), next_gap());
		repeat ($urandom_range(5, 1)) sample($urandom_range(1023, 0), hold_gap());
		if ($urandom_range(99) < 5)
			send(mk(OP_CLEAR, FORCE_W'($urandom), $urandom));
	endtask

	// A single arbitrary item, occasionally a clear.
	task automatic noise();
		logic [TIME_W-1:0] t;
		t = $urandom;
		clock_ms = t;
		send(mk(($urandom_range(9) == 0) ? OP_CLEAR : OP_SAMPLE, FORCE_W'($urandom), t));
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_data,
			input logic [CFG_DATA_W-1:0] hold, input int idle, input int n);
		int target;
		drain();
		configure(thr_data, hold);
		thr_now = int'(thr_data[FORCE_W-1:0]);
		hold_now = int'(hold);
		idle_pct = idle;
		target = sent + n;
		while (sent < target) begin
			if ($urandom_range(99) < 80)
				jump_cycle();
			else
				noise();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings (threshold 80, hold 1000 ms).
		// A clear with its other fields at their maxima, which must be ignored.
		send(mk(OP_CLEAR, '1, '1));
		// A force equal to the threshold counts as ground before take-off.
		sample_at(80, 0);
		sample_at(79, 10);
		sample_at(80, 20);
		// Take-off at 100 ms after two samples below the threshold.
		sample_at(10, 30);
		sample_at(0, 100);
		// In the air the threshold value itself is still air.
		sample_at(80, 110);
		sample_at(81, 120);
		// A broken landing pair falls back to airborne.
		sample_at(50, 130);
		sample_at(81, 200);
		sample_at(600, 350);
		// The window holds just below 1000 ms and ends exactly at 1000 ms.
		sample_at(900, 1349);
		sample_at(1023, 1350);
		// A jump across the timestamp wrap with an air time beyond 16 bits.
		sample_at(0, 32'hFFFF_FF00);
		sample_at(0, 32'hFFFF_FF10);
		sample_at(1023, 32'h0002_0000);
		sample_at(1023, 32'h0002_0000);
		// A timestamp that goes backwards leaves the window at once.
		sample_at(700, 32'h0001_FFFF);
		send(mk(OP_CLEAR, '0, '0));
		// An air time of exactly 65535 ms, the largest that is not saturated.
		sample_at(0, 0);
		sample_at(0, 5);
		sample_at(1023, 6);
		sample_at(1023, 65540);
		sample_at(512, 65540);

		// Random part over several settings. The top threshold carries junk in
		// the unused data bits. One phase runs with no idling on either side.
		run_phase({6'($urandom), 10'd1023}, 16'hFFFF, 33, 85);
		run_phase(16'd0, 16'd1, 33, 85);
		run_phase(16'd300, 16'd0, 33, 85);
		run_phase(16'd80, 16'd1000, 0, 85);
		run_phase(16'($urandom_range(1023, 0)), 16'($urandom), 33, 85);
		run_phase(16'd1022, 16'hFFFF, 33, 85);
		run_phase(16'd1, 16'd1, 33, 85);

		drain();
		repeat (4) @(posedge clk);
		$display("Sent %0d items and checked %0d status items over %0d register writes.",
			sent, board.checked, writes);
		$display("Predicted %0d take-offs and %0d landings; %0d mismatches.",
			board.takeoffs, board.landings, board.errors);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
design/jld_pkg.sv
design/jld_core.sv
design/jump_landing_detector.sv
tb/testbench.sv
